// ----- src/u16da_pkg.sv -----
// Shared types, constants and helper functions for the 16-bit binary to
// decimal ASCII converter. No dependencies.
`timescale 1ns / 1ps

package u16da_pkg;

  localparam int VALUE_W  = 16;
  localparam int CHAR_W   = 6;
  localparam int DIGIT_W  = 4;
  localparam int MULT_W   = 17;   // nine times a place weight needs 17 bits
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [2:0] pos_t;

  // decimal places, most significant first
  localparam pos_t POS_TENK  = 3'd0;
  localparam pos_t POS_THOU  = 3'd1;
  localparam pos_t POS_HUND  = 3'd2;
  localparam pos_t POS_TENS  = 3'd3;
  localparam pos_t POS_UNITS = 3'd4;

  // one queued word: the value and the place of its first digit to send
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    pos_t               first_pos;
  } item_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // k times the weight of place pos; k is a constant at each call site
  function automatic logic [MULT_W-1:0] place_multiple(input pos_t pos,
                                                       input logic [DIGIT_W-1:0] k);
    logic [MULT_W-1:0] kx;
    kx = {{(MULT_W-DIGIT_W){1'b0}}, k};
    case (pos)
      POS_TENK: place_multiple = kx * 17'd10000;
      POS_THOU: place_multiple = kx * 17'd1000;
      POS_HUND: place_multiple = kx * 17'd100;
      POS_TENS: place_multiple = kx * 17'd10;
      default:  place_multiple = kx;
    endcase
  endfunction

endpackage

// ----- src/u16da_front.sv -----
// Front end: takes words in and works out where the first significant
// digit lies. Depends on u16da_pkg.
`timescale 1ns / 1ps

module u16da_front (
  input  logic                        start,
  input  logic [u16da_pkg::VALUE_W-1:0] value,
  input  u16da_pkg::q_status_t        q_status,
  output logic                        busy,
  output logic                        push,
  output u16da_pkg::item_t            push_item
);
  import u16da_pkg::*;

  pos_t first_pos;

  // leading zero suppression: skip places above the top nonzero digit
  always_comb begin
    if (value >= 16'd10000) begin
      first_pos = POS_TENK;
    end else if (value >= 16'd1000) begin
      first_pos = POS_THOU;
    end else if (value >= 16'd100) begin
      first_pos = POS_HUND;
    end else if (value >= 16'd10) begin
      first_pos = POS_TENS;
    end else begin
      first_pos = POS_UNITS;
    end
  end

  assign busy                = q_status.full;
  assign push                = start && !q_status.full;
  assign push_item.value     = value;
  assign push_item.first_pos = first_pos;

endmodule

// ----- src/u16da_queue.sv -----
// Short queue between the front and back ends.
// Depends on u16da_pkg.
`timescale 1ns / 1ps

module u16da_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u16da_pkg::item_t  push_item,
  input  logic              pop,
  output u16da_pkg::item_t  head,
  output u16da_pkg::q_status_t status
);
  import u16da_pkg::*;

  item_t                 mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr;
  logic [Q_PTR_W-1:0]    rd_ptr;
  logic [Q_CNT_W-1:0]    count;
  logic                  do_push;
  logic                  do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- src/u16da_back.sv -----
// Back end: peels one decimal digit per cycle off the queued word and
// registers it as an ASCII character. Depends on u16da_pkg.
`timescale 1ns / 1ps

module u16da_back (
  input  logic                          clk,
  input  logic                          rst,
  input  u16da_pkg::item_t              head,
  input  u16da_pkg::q_status_t          q_status,
  output logic                          pop,
  output logic                          strobe,
  output logic [u16da_pkg::CHAR_W-1:0]  digit_char,
  output logic                          last_digit
);
  import u16da_pkg::*;

  logic               active;
  logic [VALUE_W-1:0] rest;
  pos_t               pos;
  logic [DIGIT_W-1:0] digit;
  logic [MULT_W-1:0]  sub;
  logic [VALUE_W-1:0] rest_next;
  logic               finishing;

  // digit = largest k in 1..9 with k*weight <= rest, all compares in parallel
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, rest} >= place_multiple(pos, DIGIT_W'(k))) begin
        digit = DIGIT_W'(k);
        sub   = place_multiple(pos, DIGIT_W'(k));
      end
    end
    rest_next = VALUE_W'({1'b0, rest} - sub);
  end

  assign finishing = active && (pos == POS_UNITS);
  // next word is taken in the cycle the units digit is registered
  assign pop       = (!active || finishing) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (finishing) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      digit_char <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
      last_digit <= finishing;
    end
    if (pop) begin
      rest <= head.value;
      pos  <= head.first_pos;
    end else if (active) begin
      rest <= rest_next;
      pos  <= pos + 3'd1;
    end
  end

endmodule

// ----- src/uint16_to_decimal_ascii.sv -----
// Top level of the 16-bit binary to decimal ASCII converter.
// Depends on u16da_pkg, u16da_front, u16da_queue and u16da_back.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+-------------------------------
//   input    | value[15:0]                   | start, busy (taken: start&!busy)
//   result   | digit_char[5:0], last_digit   | strobe, one cycle, no stall
//
// A word of n decimal digits (1 to 5) holds the digit unit until all n are
// out, one digit per cycle; its first character is registered in the queue,
// the digit unit and the output register. The two-entry queue lets words in
// while the digit unit works and raises busy when full. Synchronous reset
// empties the queue and idles the digit unit. Results cannot be held off.
`timescale 1ns / 1ps

module uint16_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [u16da_pkg::VALUE_W-1:0] value,
  output logic                          strobe,
  output logic [u16da_pkg::CHAR_W-1:0]  digit_char,
  output logic                          last_digit
);
  import u16da_pkg::*;

  q_status_t q_status;
  item_t     push_item;
  item_t     head;
  logic      push;
  logic      pop;

  u16da_front u_front (
    .start     (start),
    .value     (value),
    .q_status  (q_status),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  u16da_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  u16da_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  // digits of one word leave in consecutive cycles
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_digit |=> strobe)
    else $error("digit run broken before units digit");

  // a run never opens with a zero unless it is the lone units digit
  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_digit && !$past(strobe && !last_digit) |-> digit_char != ASCII_ZERO)
    else $error("leading zero sent");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9))
    else $error("character out of digit range");

  // an accepted word is in the queue at the next edge
  a_word_queued: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !q_status.empty)
    else $error("accepted word lost");

endmodule
